// ----- rtl/segment_segment_distance_3d_macros.svh -----
// ----------------------------------------------------------------------------
// Segment distance assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_DISTANCE_3D_MACROS_SVH
`define SEGMENT_SEGMENT_DISTANCE_3D_MACROS_SVH
`ifndef SYNTHESIS
`define SSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");
`define SSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");
`else
`define SSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment distance package
// Register width, reset value, dot and product term indexes, divider lanes.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int CFG_WIDTH = 32;
    typedef logic [CFG_WIDTH-1:0] t_cfg_word;
    localparam t_cfg_word LIMIT_RESET = 32'd1;

    // dot products
    localparam int D_UU = 0;
    localparam int D_UV = 1;
    localparam int D_VV = 2;
    localparam int D_UW = 3;
    localparam int D_VW = 4;
    localparam int N_DOT = 5;

    // second-order products
    localparam int M_UUVV = 0;
    localparam int M_UVUV = 1;
    localparam int M_UVVW = 2;
    localparam int M_VVUW = 3;
    localparam int M_UUVW = 4;
    localparam int M_UVUW = 5;
    localparam int N_MUL  = 6;

    // divider lanes
    localparam int L_S = 0;
    localparam int L_T = 1;

endpackage

// ----- rtl/ssd_in_if.sv -----
// ----------------------------------------------------------------------------
// Segment pair channel
// Valid/ready channel carrying the twelve endpoint coordinates.
// ----------------------------------------------------------------------------
interface ssd_in_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_start_z;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] a_end_z;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_start_z;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;
    logic signed [COORD_WIDTH-1:0] b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );
endinterface

// ----- rtl/ssd_out_if.sv -----
// ----------------------------------------------------------------------------
// Segment distance result channel
// Valid/ready channel carrying the distance and both closest points.
// ----------------------------------------------------------------------------
interface ssd_out_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic [COORD_WIDTH:0]          gap_length;
    logic signed [COORD_WIDTH-1:0] near_a_x;
    logic signed [COORD_WIDTH-1:0] near_a_y;
    logic signed [COORD_WIDTH-1:0] near_a_z;
    logic signed [COORD_WIDTH-1:0] near_b_x;
    logic signed [COORD_WIDTH-1:0] near_b_y;
    logic signed [COORD_WIDTH-1:0] near_b_z;

    modport source (
        output valid, gap_length, near_a_x, near_a_y, near_a_z,
               near_b_x, near_b_y, near_b_z,
        input  ready
    );
    modport sink (
        input  valid, gap_length, near_a_x, near_a_y, near_a_z,
               near_b_x, near_b_y, near_b_z,
        output ready
    );
endinterface

// ----- rtl/ssd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Segment distance configuration channel
// Valid/ready write channel for the near-zero limit register.
// ----------------------------------------------------------------------------
interface ssd_cfg_if import ssd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/segment_segment_distance_3d.sv -----
// ----------------------------------------------------------------------------
// Closest points between two 3D segments
// Streaming fixed-point pipeline: dot products, edge clamping, two
// restoring dividers, closest points and an integer square root.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one word per segment pair (twelve signed Q coordinates).
//   o_out  : one word per pair: gap_length and the closest point on each
//            segment.
//   i_cfg  : writes near_zero_limit; always ready, write only while idle.
// Pipeline: o_out.valid rises once an accepted word has passed six
//   arithmetic stages (wide products split into half-width partial
//   products), one divider setup stage, one stage per quotient bit, four
//   point/gap stages and one stage per root bit.
// Throughput: one word per cycle while o_out.ready is high; every stage has
//   a valid bit, loads when empty or its successor loads; bubbles close up.
// Reset: empties the pipeline and sets near_zero_limit to 1.
// Stall: while o_out.ready is low the result holds and the stages behind
//   it keep filling; i_in.ready drops once every stage holds a word.
// ----------------------------------------------------------------------------
`include "segment_segment_distance_3d_macros.svh"

module segment_segment_distance_3d import ssd_pkg::*; #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssd_cfg_if.sink   i_cfg,
    ssd_in_if.sink    i_in,
    ssd_out_if.source o_out
);

    localparam int C    = COORD_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int SH   = 2 * F;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW + 2;
    localparam int HW   = PW / 2;
    localparam int MW   = 2 * PW;
    localparam int NW   = 2 * PW + 2 * F + 2;
    localparam int QW   = F + 1;
    localparam int SUW  = QW + 1 + DW;
    localparam int DPW  = C + F + 4;
    localparam int DL   = DPW / 2;
    localparam int DH   = DPW - DL;
    localparam int SQW  = 2 * DPW + 2;
    localparam int NQW  = SQW - SH;
    localparam int TW   = NQW + 1;
    localparam int RW   = C + 1;
    localparam int HALF = 1 << (F - 1);
    localparam int DIVI = 6;
    localparam int DIVL = 6 + F;
    localparam int PA   = 7 + F;
    localparam int PB   = 8 + F;
    localparam int PC   = 9 + F;
    localparam int PS   = 10 + F;
    localparam int SQ0  = 11 + F;
    localparam int NST  = 11 + F + RW;

    function automatic logic signed [PW-1:0] f_dot(
        input logic signed [DW-1:0] x [3],
        input logic signed [DW-1:0] y [3]
    );
        return PW'(x[0]) * PW'(y[0]) + PW'(x[1]) * PW'(y[1]) + PW'(x[2]) * PW'(y[2]);
    endfunction

    // ---------------- configuration ----------------
    t_cfg_word r_limit;
    logic signed [NW-1:0] thr;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end
    assign thr = $signed(NW'(r_limit)) <<< SH;

    // ---------------- pipeline control ----------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] ld;

    assign ld[NST-1] = !r_vld[NST-1] || o_out.ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_ld
        assign ld[k] = !r_vld[k] || ld[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end
    assign i_in.ready = ld[0];

    // ---------------- geometry, carried to PA ----------------
    logic signed [DW-1:0] r_u  [PA+1][3];
    logic signed [DW-1:0] r_v  [PA+1][3];
    logic signed [DW-1:0] r_w  [PA+1][3];
    logic signed [C-1:0]  r_pa [PA+1][3];
    logic signed [C-1:0]  r_pb [PA+1][3];
    logic signed [C-1:0]  as_c [3];
    logic signed [C-1:0]  ae_c [3];
    logic signed [C-1:0]  bs_c [3];
    logic signed [C-1:0]  be_c [3];

    assign as_c = '{i_in.a_start_x, i_in.a_start_y, i_in.a_start_z};
    assign ae_c = '{i_in.a_end_x, i_in.a_end_y, i_in.a_end_z};
    assign bs_c = '{i_in.b_start_x, i_in.b_start_y, i_in.b_start_z};
    assign be_c = '{i_in.b_end_x, i_in.b_end_y, i_in.b_end_z};

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_u[0][j]  <= DW'(ae_c[j]) - DW'(as_c[j]);
                r_v[0][j]  <= DW'(be_c[j]) - DW'(bs_c[j]);
                r_w[0][j]  <= DW'(as_c[j]) - DW'(bs_c[j]);
                r_pa[0][j] <= as_c[j];
                r_pb[0][j] <= bs_c[j];
            end
        end
    end

    for (genvar k = 1; k <= PA; k++) begin : g_geo
        always_ff @(posedge i_clk) begin
            if (ld[k]) begin
                r_u[k]  <= r_u[k-1];
                r_v[k]  <= r_v[k-1];
                r_w[k]  <= r_w[k-1];
                r_pa[k] <= r_pa[k-1];
                r_pb[k] <= r_pb[k-1];
            end
        end
    end

    // ---------------- dot products, stages 1..4 ----------------
    logic signed [PW-1:0] r_dot [1:4][N_DOT];

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_dot[1][D_UU] <= f_dot(r_u[0], r_u[0]);
            r_dot[1][D_UV] <= f_dot(r_u[0], r_v[0]);
            r_dot[1][D_VV] <= f_dot(r_v[0], r_v[0]);
            r_dot[1][D_UW] <= f_dot(r_u[0], r_w[0]);
            r_dot[1][D_VW] <= f_dot(r_v[0], r_w[0]);
        end
        if (ld[2]) begin
            r_dot[2] <= r_dot[1];
        end
        if (ld[3]) begin
            r_dot[3] <= r_dot[2];
        end
        if (ld[4]) begin
            r_dot[4] <= r_dot[3];
        end
    end

    // ---------------- second-order products, stages 2 and 3 ----------------
    // half-width partial products in stage 2, recombined in stage 3
    logic signed [PW-1:0]   mx [N_MUL];
    logic signed [PW-1:0]   my [N_MUL];
    logic signed [2*HW-1:0] r_pp_hh [N_MUL];
    logic signed [2*HW:0]   r_pp_hl [N_MUL];
    logic signed [2*HW:0]   r_pp_lh [N_MUL];
    logic [2*HW-1:0]        r_pp_ll [N_MUL];
    logic signed [MW-1:0]   r_mul [N_MUL];

    always_comb begin
        mx[M_UUVV] = r_dot[1][D_UU];
        my[M_UUVV] = r_dot[1][D_VV];
        mx[M_UVUV] = r_dot[1][D_UV];
        my[M_UVUV] = r_dot[1][D_UV];
        mx[M_UVVW] = r_dot[1][D_UV];
        my[M_UVVW] = r_dot[1][D_VW];
        mx[M_VVUW] = r_dot[1][D_VV];
        my[M_VVUW] = r_dot[1][D_UW];
        mx[M_UUVW] = r_dot[1][D_UU];
        my[M_UUVW] = r_dot[1][D_VW];
        mx[M_UVUW] = r_dot[1][D_UV];
        my[M_UVUW] = r_dot[1][D_UW];
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            for (int i = 0; i < N_MUL; i++) begin
                r_pp_hh[i] <= $signed(mx[i][PW-1:HW]) * $signed(my[i][PW-1:HW]);
                r_pp_hl[i] <= $signed(mx[i][PW-1:HW]) * $signed({1'b0, my[i][HW-1:0]});
                r_pp_lh[i] <= $signed({1'b0, mx[i][HW-1:0]}) * $signed(my[i][PW-1:HW]);
                r_pp_ll[i] <= mx[i][HW-1:0] * my[i][HW-1:0];
            end
        end
        if (ld[3]) begin
            for (int i = 0; i < N_MUL; i++) begin
                r_mul[i] <= (MW'(r_pp_hh[i]) <<< (2 * HW))
                          + ((MW'(r_pp_hl[i]) + MW'(r_pp_lh[i])) <<< HW)
                          + MW'(r_pp_ll[i]);
            end
        end
    end

    // ---------------- D and numerators, stage 4 ----------------
    logic signed [NW-1:0] r_par4;
    logic signed [NW-1:0] r_sn4;
    logic signed [NW-1:0] r_tn4;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_par4 <= NW'(r_mul[M_UUVV]) - NW'(r_mul[M_UVUV]);
            r_sn4  <= NW'(r_mul[M_UVVW]) - NW'(r_mul[M_VVUW]);
            r_tn4  <= NW'(r_mul[M_UUVW]) - NW'(r_mul[M_UVUW]);
        end
    end

    // ---------------- edge clamping, stage 5 ----------------
    logic signed [NW-1:0] uus, uvs, vvs, uws, vws;
    logic signed [NW-1:0] n_sn, n_sd, n_tn, n_td, n_m;
    logic signed [NW-1:0] r_sn5, r_sd5, r_tn5, r_td5;

    assign uus = NW'(r_dot[4][D_UU]) <<< SH;
    assign uvs = NW'(r_dot[4][D_UV]) <<< SH;
    assign vvs = NW'(r_dot[4][D_VV]) <<< SH;
    assign uws = NW'(r_dot[4][D_UW]) <<< SH;
    assign vws = NW'(r_dot[4][D_VW]) <<< SH;

    always_comb begin
        n_m = '0;
        if (r_par4 < thr) begin
            n_sn = '0;
            n_sd = NW'(1) <<< (2 * SH);
            n_tn = vws;
            n_td = vvs;
        end else begin
            n_sn = r_sn4;
            n_tn = r_tn4;
            n_sd = r_par4;
            n_td = r_par4;
            priority if (n_sn < 0) begin
                n_sn = '0;
                n_tn = vws;
                n_td = vvs;
            end else if (n_sn > n_sd) begin
                n_sn = n_sd;
                n_tn = vws + uvs;
                n_td = vvs;
            end
        end
        if (n_tn < 0 || n_tn > n_td) begin
            if (n_tn < 0) begin
                n_tn = '0;
                n_m  = -uws;
            end else begin
                n_tn = n_td;
                n_m  = uvs - uws;
            end
            priority if (n_m < 0) begin
                n_sn = '0;
            end else if (n_m > uus) begin
                n_sn = n_sd;
            end else begin
                n_sn = n_m;
                n_sd = uus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_sn5 <= n_sn;
            r_sd5 <= n_sd;
            r_tn5 <= n_tn;
            r_td5 <= n_td;
        end
    end

    // ---------------- dividers, setup stage and one stage per bit ----------------
    logic          r_z   [DIVI:DIVL][2];
    logic          r_one [DIVI:DIVL][2];
    logic [NW-1:0] r_rem [DIVI:DIVL][2];
    logic [NW-1:0] r_den [DIVI:DIVL][2];
    logic [F-1:0]  r_q   [DIVI:DIVL][2];
    logic signed [NW-1:0] ln_num [2];
    logic signed [NW-1:0] ln_den [2];

    assign ln_num = '{r_sn5, r_tn5};
    assign ln_den = '{r_sd5, r_td5};

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [NW-1:0] mag;
        logic                 zero;

        assign mag  = ln_num[l][NW-1] ? -ln_num[l] : ln_num[l];
        assign zero = (mag < thr) || (ln_den[l] <= 0) || (ln_num[l] <= 0);

        always_ff @(posedge i_clk) begin
            if (ld[DIVI]) begin
                r_z[DIVI][l]   <= zero;
                r_one[DIVI][l] <= !zero && (ln_num[l] >= ln_den[l]);
                r_rem[DIVI][l] <= ln_num[l];
                r_den[DIVI][l] <= ln_den[l];
                r_q[DIVI][l]   <= '0;
            end
        end

        for (genvar k = DIVI + 1; k <= DIVL; k++) begin : g_div
            logic [NW-1:0] rem2;

            assign rem2 = r_rem[k-1][l] << 1;

            always_ff @(posedge i_clk) begin
                if (ld[k]) begin
                    r_z[k][l]   <= r_z[k-1][l];
                    r_one[k][l] <= r_one[k-1][l];
                    r_den[k][l] <= r_den[k-1][l];
                    if (rem2 >= r_den[k-1][l]) begin
                        r_rem[k][l] <= rem2 - r_den[k-1][l];
                        r_q[k][l]   <= {r_q[k-1][l][F-2:0], 1'b1};
                    end else begin
                        r_rem[k][l] <= rem2;
                        r_q[k][l]   <= {r_q[k-1][l][F-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- parameter times direction, stage PA ----------------
    logic [QW-1:0]         par_q [2];
    logic signed [SUW-1:0] r_su [3];
    logic signed [SUW-1:0] r_tv [3];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            priority if (r_z[DIVL][l]) begin
                par_q[l] = '0;
            end else if (r_one[DIVL][l]) begin
                par_q[l] = QW'(1) << F;
            end else begin
                par_q[l] = {1'b0, r_q[DIVL][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[PA]) begin
            for (int j = 0; j < 3; j++) begin
                r_su[j] <= $signed({1'b0, par_q[L_S]}) * r_u[PA-1][j];
                r_tv[j] <= $signed({1'b0, par_q[L_T]}) * r_v[PA-1][j];
            end
        end
    end

    // ---------------- points and gap vector, stage PB ----------------
    logic signed [C-1:0]   r_na [PB:NST-1][3];
    logic signed [C-1:0]   r_nb [PB:NST-1][3];
    logic signed [DPW-1:0] r_dp [3];

    always_ff @(posedge i_clk) begin
        if (ld[PB]) begin
            for (int j = 0; j < 3; j++) begin
                r_na[PB][j] <= r_pa[PA][j] + C'((r_su[j] + SUW'(HALF)) >>> F);
                r_nb[PB][j] <= r_pb[PA][j] + C'((r_tv[j] + SUW'(HALF)) >>> F);
                r_dp[j]     <= (DPW'(r_w[PA][j]) <<< F) + DPW'(r_su[j]) - DPW'(r_tv[j]);
            end
        end
    end

    for (genvar k = PB + 1; k < NST; k++) begin : g_pts
        always_ff @(posedge i_clk) begin
            if (ld[k]) begin
                r_na[k] <= r_na[k-1];
                r_nb[k] <= r_nb[k-1];
            end
        end
    end

    // ---------------- squared gap: partials at PC, sum at PS ----------------
    logic signed [2*DH-1:0] r_sq_hh [3];
    logic signed [DH+DL:0]  r_sq_hl [3];
    logic [2*DL-1:0]        r_sq_ll [3];
    logic signed [SQW-1:0]  sq;
    logic [NQW-1:0]         r_srem [PS:NST-1];
    logic [RW-1:0]          r_root [PS:NST-1];

    always_ff @(posedge i_clk) begin
        if (ld[PC]) begin
            for (int j = 0; j < 3; j++) begin
                r_sq_hh[j] <= $signed(r_dp[j][DPW-1:DL]) * $signed(r_dp[j][DPW-1:DL]);
                r_sq_hl[j] <= $signed(r_dp[j][DPW-1:DL]) * $signed({1'b0, r_dp[j][DL-1:0]});
                r_sq_ll[j] <= r_dp[j][DL-1:0] * r_dp[j][DL-1:0];
            end
        end
    end

    assign sq = ((SQW'(r_sq_hh[0]) + SQW'(r_sq_hh[1]) + SQW'(r_sq_hh[2])) <<< (2 * DL))
              + ((SQW'(r_sq_hl[0]) + SQW'(r_sq_hl[1]) + SQW'(r_sq_hl[2])) <<< (DL + 1))
              + (SQW'(r_sq_ll[0]) + SQW'(r_sq_ll[1]) + SQW'(r_sq_ll[2]));

    always_ff @(posedge i_clk) begin
        if (ld[PS]) begin
            r_srem[PS] <= NQW'(sq >> SH);
            r_root[PS] <= '0;
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        localparam int K = SQ0 + i;
        localparam int B = RW - 1 - i;
        logic [TW-1:0] trial;

        assign trial = (TW'(r_root[K-1]) << (B + 1)) + (TW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (ld[K]) begin
                if (TW'(r_srem[K-1]) >= trial) begin
                    r_srem[K] <= NQW'(TW'(r_srem[K-1]) - trial);
                    r_root[K] <= r_root[K-1] | (RW'(1) << B);
                end else begin
                    r_srem[K] <= r_srem[K-1];
                    r_root[K] <= r_root[K-1];
                end
            end
        end
    end

    // ---------------- result ----------------
    assign o_out.valid      = r_vld[NST-1];
    assign o_out.gap_length = r_root[NST-1];
    assign o_out.near_a_x   = r_na[NST-1][0];
    assign o_out.near_a_y   = r_na[NST-1][1];
    assign o_out.near_a_z   = r_na[NST-1][2];
    assign o_out.near_b_x   = r_nb[NST-1][0];
    assign o_out.near_b_y   = r_nb[NST-1][1];
    assign o_out.near_b_z   = r_nb[NST-1][2];

    // ---------------- assertions ----------------
    `SSD_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])
    `SSD_ASSERT_IMP(a_den_nonneg, i_clk, i_rst_n, r_vld[5], !r_sd5[NW-1] && !r_td5[NW-1])
    `SSD_ASSERT_IMP(a_s_rem_below, i_clk, i_rst_n, r_vld[DIVL] && !r_z[DIVL][L_S] && !r_one[DIVL][L_S], r_rem[DIVL][L_S] < r_den[DIVL][L_S])
    `SSD_ASSERT_IMP(a_t_rem_below, i_clk, i_rst_n, r_vld[DIVL] && !r_z[DIVL][L_T] && !r_one[DIVL][L_T], r_rem[DIVL][L_T] < r_den[DIVL][L_T])

endmodule
